/* rtl/mct_pkg.sv */
// Shared types and constants for the mean census transform block.
`default_nettype none
package mct_pkg;
    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int AddrW     = $clog2(MaxWidth);
    localparam int Lines     = 6;
    localparam int WinRows   = 7;
    localparam int WinCols   = 9;
    localparam int HalfRows  = 3;
    localparam int HalfCols  = 4;
    localparam int CodeW     = WinRows * WinCols - 1;
    localparam int CoordW    = 11;
    localparam int CfgW      = 12;
    localparam int RowSumW   = 12;
    localparam int SumW      = 14;
    localparam int ProdW     = 24;
    // floor(sum/63) estimate: (sum * 1040) >> 16 is exact or one low over 0..16065
    localparam logic [10:0] RecipMul = 11'd1040;
    localparam logic [5:0]  WinArea  = 6'd63;

    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    typedef logic [WinRows-1:0][WinCols-1:0][7:0] t_win;
    typedef logic [Lines*8-1:0] t_line_word;

    typedef struct packed {
        logic [CoordW-1:0] row;
        logic [CoordW-1:0] col;
        logic              done;
    } t_meta;
endpackage
`default_nettype wire

/* rtl/mean_census_transform_top.sv */
// Top level: raster counters, line stores, 7x9 window and census pipeline.
//  channel | direction | handshake         | payload
//  pixel   | in        | i_valid / o_stall | i_pixel
//  census  | out       | o_valid / i_stall | o_census_bits, o_center_row, o_center_col,
//          |           |                   | o_frame_done
//  config  | in        | i_cfg_wr_en       | i_cfg_index, i_cfg_data
// One pixel beat per cycle while o_stall is low; a result is registered through the input, window and core stages.
// After reset the line stores are swept to zero; no pixel is taken meanwhile.
// The whole pipeline holds while a result waits under i_stall; o_stall follows at once.
`default_nettype none
module mean_census_transform_top
    import mct_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_pixel,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CodeW-1:0]       o_census_bits,
    output logic [CoordW-1:0]      o_center_row,
    output logic [CoordW-1:0]      o_center_col,
    output logic                   o_frame_done,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_index,
    input  wire logic [CfgW-1:0]   i_cfg_data
);
    logic [CfgW-1:0]   r_width, r_height, w_eff, h_eff;
    logic [CoordW-1:0] r_row, r_col;
    logic              en, busy, accept, col_end, row_end;
    logic              r_a_valid, r_a_emit, r_b_emit;
    logic [7:0]        r_a_px;
    logic [AddrW-1:0]  r_a_addr;
    t_meta             r_a_meta, r_b_meta, core_meta;
    t_line_word        rd_word, wr_word;
    logic [WinRows-1:0][7:0] column;
    t_win              r_win;
    logic              core_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CfgW'(640);
            r_height <= CfgW'(480);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CfgWidth:  r_width  <= i_cfg_data;
                CfgHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = r_width;
        if (r_width == '0) w_eff = CfgW'(1);
        else if (r_width > CfgW'(MaxWidth)) w_eff = CfgW'(MaxWidth);
        h_eff = r_height;
        if (r_height == '0) h_eff = CfgW'(1);
        else if (r_height > CfgW'(MaxHeight)) h_eff = CfgW'(MaxHeight);
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = busy || !en;
    assign accept  = i_valid && !o_stall;
    assign col_end = ({1'b0, r_col} + 1'b1) >= w_eff;
    assign row_end = ({1'b0, r_row} + 1'b1) >= h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_emit  <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
            r_b_emit  <= r_a_valid && r_a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_px        <= i_pixel;
            r_a_addr      <= AddrW'(r_col);
            r_a_emit      <= r_row >= CoordW'(2 * HalfRows) && r_col >= CoordW'(2 * HalfCols);
            r_a_meta.row  <= r_row - CoordW'(HalfRows);
            r_a_meta.col  <= r_col - CoordW'(HalfCols);
            r_a_meta.done <= row_end && col_end;
            r_b_meta      <= r_a_meta;
        end
    end

    // column of the window: oldest line on top, new pixel at the bottom
    always_comb begin
        for (int k = 0; k < Lines; k++) column[k] = rd_word[8*k +: 8];
        column[Lines] = r_a_px;
        for (int k = 0; k < Lines; k++) wr_word[8*k +: 8] = column[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (en && r_a_valid) begin
            for (int y = 0; y < WinRows; y++) begin
                for (int x = 0; x < WinCols - 1; x++) r_win[y][x] <= r_win[y][x+1];
                r_win[y][WinCols-1] <= column[y];
            end
        end
    end

    mct_line_store u_lines (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (AddrW'(r_col)),
        .i_wr_en   (en && r_a_valid),
        .i_wr_addr (r_a_addr),
        .i_wr_data (wr_word),
        .o_rd_data (rd_word),
        .o_busy    (busy)
    );

    mct_census_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_emit),
        .i_win   (r_win),
        .i_meta  (r_b_meta),
        .o_valid (core_valid),
        .o_code  (o_census_bits),
        .o_meta  (core_meta)
    );

    assign o_valid      = core_valid;
    assign o_center_row = core_meta.row;
    assign o_center_col = core_meta.col;
    assign o_frame_done = core_meta.done;
endmodule
`default_nettype wire

/* rtl/mct_line_store.sv */
// Six line stores packed as one word per column, with clearing sweep after reset.
`default_nettype none
module mct_line_store
    import mct_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [AddrW-1:0] i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [AddrW-1:0] i_wr_addr,
    input  wire t_line_word       i_wr_data,
    output t_line_word            o_rd_data,
    output logic                  o_busy
);
    t_line_word       r_mem [MaxWidth];
    t_line_word       r_rd;
    logic             r_busy;
    logic [AddrW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AddrW'(MaxWidth - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // same-column write in this cycle (one-pixel-wide frames) is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_addr == i_rd_addr) r_rd <= i_wr_data;
            else r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_busy;
endmodule
`default_nettype wire

/* rtl/mct_census_core.sv */
// Window mean and census code pipeline: row sums, total, mean, compare.
`default_nettype none
module mct_census_core
    import mct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_win        i_win,
    input  wire t_meta       i_meta,
    output logic             o_valid,
    output logic [CodeW-1:0] o_code,
    output t_meta            o_meta
);
    logic [3:0] r_v;
    t_win       r_win_c, r_win_d, r_win_e, r_win_f;
    t_meta      r_meta_c, r_meta_d, r_meta_e, r_meta_f, r_meta_g;
    logic [WinRows-1:0][RowSumW-1:0] r_rsum, n_rsum;
    logic [SumW-1:0]  r_sum_d, r_sum_e, n_sum;
    logic [ProdW-1:0] r_prod;
    logic [7:0]       r_mean, n_mean;
    logic [7:0]       q_est;
    logic [SumW-1:0]  rem;
    logic [CodeW-1:0] r_code, n_code;
    logic             r_out_v;

    always_comb begin
        for (int y = 0; y < WinRows; y++) begin
            n_rsum[y] = '0;
            for (int x = 0; x < WinCols; x++)
                n_rsum[y] = n_rsum[y] + RowSumW'(i_win[y][x]);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int y = 0; y < WinRows; y++) n_sum = n_sum + SumW'(r_rsum[y]);
    end

    always_comb begin
        q_est  = r_prod[ProdW-1:16];
        rem    = r_sum_e - SumW'(q_est) * SumW'(WinArea);
        n_mean = (rem >= SumW'(WinArea)) ? q_est + 8'd1 : q_est;
    end

    always_comb begin
        int b;
        b = CodeW - 1;
        n_code = '0;
        for (int y = 0; y < WinRows; y++)
            for (int x = 0; x < WinCols; x++)
                if (!(y == HalfRows && x == HalfCols)) begin
                    n_code[b] = r_win_f[y][x] < r_mean;
                    b = b - 1;
                end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[2:0], i_valid};
            r_out_v <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsum   <= n_rsum;
            r_win_c  <= i_win;
            r_meta_c <= i_meta;
            r_sum_d  <= n_sum;
            r_win_d  <= r_win_c;
            r_meta_d <= r_meta_c;
            r_prod   <= ProdW'(r_sum_d) * ProdW'(RecipMul);
            r_sum_e  <= r_sum_d;
            r_win_e  <= r_win_d;
            r_meta_e <= r_meta_d;
            r_mean   <= n_mean;
            r_win_f  <= r_win_e;
            r_meta_f <= r_meta_e;
            r_code   <= n_code;
            r_meta_g <= r_meta_f;
        end
    end

    assign o_valid = r_out_v;
    assign o_code  = r_code;
    assign o_meta  = r_meta_g;
endmodule
`default_nettype wire

/* dv/mean_census_transform_top_test.sv */
// Self-checking testbench for the mean census transform block.
`default_nettype none
module mean_census_transform_top_test;
    import mct_pkg::*;

    typedef struct packed {
        logic [CodeW-1:0]  bits;
        logic [CoordW-1:0] row;
        logic [CoordW-1:0] col;
        logic              done;
    } t_census;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_pixel;
    logic              o_valid;
    logic              i_stall;
    logic [CodeW-1:0]  o_census_bits;
    logic [CoordW-1:0] o_center_row;
    logic [CoordW-1:0] o_center_col;
    logic              o_frame_done;
    logic              i_cfg_wr_en;
    logic              i_cfg_index;
    logic [CfgW-1:0]   i_cfg_data;

    mean_census_transform_top dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the block
    logic [7:0]      line_mem [Lines][MaxWidth];
    logic [7:0]      win_mem  [WinRows][WinCols];
    int unsigned     row_cnt, col_cnt;
    logic [CfgW-1:0] cfg_width, cfg_height;

    logic [7:0] pixel_q  [$];
    t_census    census_q [$];

    bit quiet;
    int errors;
    int send_gap, recv_gap, hold_left, results_seen, idle_cycles;
    bit hold_done;

    function automatic void census_predict(input logic [7:0] px);
        int unsigned w, h, c_idx, sum, mean;
        logic [7:0]  column [WinRows];
        t_census     res;
        w = (cfg_width == 0) ? 1 : (cfg_width > MaxWidth ? MaxWidth : cfg_width);
        h = (cfg_height == 0) ? 1 : (cfg_height > MaxHeight ? MaxHeight : cfg_height);
        c_idx = (col_cnt < MaxWidth) ? col_cnt : MaxWidth - 1;
        for (int k = 0; k < Lines; k++) column[k] = line_mem[k][c_idx];
        column[Lines] = px;
        for (int k = 0; k < Lines; k++) line_mem[k][c_idx] = column[k+1];
        for (int y = 0; y < WinRows; y++) begin
            for (int x = 0; x < WinCols - 1; x++) win_mem[y][x] = win_mem[y][x+1];
            win_mem[y][WinCols-1] = column[y];
        end
        if (row_cnt >= 2 * HalfRows && col_cnt >= 2 * HalfCols) begin
            sum = 0;
            res = '0;
            foreach (win_mem[y, x]) sum += win_mem[y][x];
            mean = sum / (WinRows * WinCols);
            for (int y = 0; y < WinRows; y++)
                for (int x = 0; x < WinCols; x++)
                    if (!(y == HalfRows && x == HalfCols))
                        res.bits = {res.bits[CodeW-2:0], (win_mem[y][x] < mean)};
            res.row  = CoordW'(row_cnt - HalfRows);
            res.col  = CoordW'(col_cnt - HalfCols);
            res.done = (row_cnt + 1 >= h) && (col_cnt + 1 >= w);
            census_q.push_back(res);
        end
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                census_predict(i_pixel);
                void'(pixel_q.pop_front());
            end
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pixel_q.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
                send_gap = $urandom_range(0, 16);
                i_valid  <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                i_valid <= 1'b1;
                i_pixel <= pixel_q[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                t_census got;
                t_census want;
                got = '{o_census_bits, o_center_row, o_center_col, o_frame_done};
                results_seen++;
                if (census_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = census_q.pop_front();
                    if (got.bits !== want.bits) begin
                        $display("%0t: census_bits exp %h got %h", $time, want.bits, got.bits);
                        errors++;
                    end
                    if (got.row !== want.row) begin
                        $display("%0t: center_row exp %0d got %0d", $time, want.row, got.row);
                        errors++;
                    end
                    if (got.col !== want.col) begin
                        $display("%0t: center_col exp %0d got %0d", $time, want.col, got.col);
                        errors++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: frame_done exp %0d got %0d", $time, want.done, got.done);
                        errors++;
                    end
                end
            end
            // long hold-off once, in the first small frames, so the block backs up
            if (!hold_done && results_seen >= 1) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                recv_gap = $urandom_range(0, 16);
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic cfg_write(input logic idx, input logic [CfgW-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CfgWidth) cfg_width = val;
        else cfg_height = val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic drain;
        while (pixel_q.size() > 0 || i_valid || census_q.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // texture: 0 uniform, 1 near a base level, 2 constant
    task automatic queue_pixels(input int n, input int style);
        int base;
        base = $urandom_range(0, 255);
        repeat (n) begin
            case (style)
                0: pixel_q.push_back(8'($urandom_range(0, 255)));
                1: pixel_q.push_back(8'(base + $urandom_range(0, 6) - 3));
                default: pixel_q.push_back(8'(base));
            endcase
        end
    endtask

    initial begin
        int random_items, w, h, n;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel     <= '0;
        i_stall     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CfgWidth;
        i_cfg_data  <= '0;
        foreach (line_mem[k, x]) line_mem[k][x] = '0;
        foreach (win_mem[y, x]) win_mem[y][x] = '0;
        row_cnt = 0;
        col_cnt = 0;
        cfg_width  = 640;
        cfg_height = 480;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest frame: black, white, checkerboard, lone dark centre
        cfg_write(CfgWidth, CfgW'(9));
        cfg_write(CfgHeight, CfgW'(7));
        repeat (63) pixel_q.push_back(8'd0);
        repeat (63) pixel_q.push_back(8'd255);
        for (int i = 0; i < 63; i++) pixel_q.push_back(i[0] ? 8'd255 : 8'd0);
        for (int i = 0; i < 63; i++) pixel_q.push_back(i == 31 ? 8'd0 : 8'd200);
        drain();

        // zero size reads as 1x1: consumed, nothing out
        cfg_write(CfgWidth, CfgW'(0));
        cfg_write(CfgHeight, CfgW'(0));
        queue_pixels(20, 0);
        drain();

        // widest row (saturated), start of a frame
        cfg_write(CfgWidth, 12'hFFF);
        cfg_write(CfgHeight, CfgW'(7));
        queue_pixels(256, 0);
        drain();

        // tallest frame (saturated), partial, then height rewritten to exactly 2048 mid-frame
        cfg_write(CfgWidth, CfgW'(9));
        cfg_write(CfgHeight, 12'hFFF);
        queue_pixels(9 * 20, 1);
        drain();
        cfg_write(CfgHeight, CfgW'(2048));
        queue_pixels(9 * 5, 0);
        drain();

        random_items = 0;
        while (random_items < 700) begin
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(0, 8);
                h = $urandom_range(0, 6);
            end else begin
                w = $urandom_range(9, 24);
                h = $urandom_range(7, 12);
            end
            if ($urandom_range(0, 1)) cfg_write(CfgWidth, CfgW'(w));
            if ($urandom_range(0, 1)) cfg_write(CfgHeight, CfgW'(h));
            n = $urandom_range(20, 300);
            queue_pixels(n, $urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1));
            if (w >= 9 && h >= 7) random_items += n;
            drain();
        end

        // tail without idling
        quiet = 1;
        cfg_write(CfgWidth, CfgW'(16));
        cfg_write(CfgHeight, CfgW'(8));
        queue_pixels(256, 0);
        drain();
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

/* mean_census_transform_top.f */
rtl/mct_pkg.sv
rtl/mct_line_store.sv
rtl/mct_census_core.sv
rtl/mean_census_transform_top.sv
dv/mean_census_transform_top_test.sv
